FILE: sv/pf_pkg.sv
`default_nettype none

package pf_pkg;

    // Width of the number that is factored and of each reported factor.
    localparam int VALUE_W = 32;
    // Trial divisors never pass 2^(VALUE_W/2), so one extra bit holds them.
    localparam int DIV_W = VALUE_W / 2 + 1;
    // One divider iteration per quotient bit.
    localparam int STEP_W = $clog2(VALUE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);
    // At most 32 results per run; the trial loop stops after 31 factors.
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 5'd31;
    localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(2);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture a new number, restart at divisor two
        logic load_div;   // start a division of the remainder by the divisor
        logic div_step;   // one restoring divider iteration
        logic inc_div;    // move on to the next trial divisor
        logic emit_div;   // report the divisor, keep the quotient
        logic emit_rem;   // report the remainder as the final prime
        logic emit_none;  // report the no-factors result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_small;  // remainder below two
        logic div_done;   // the divider is on its final iteration
        logic stop_trial; // divisor above quotient, or result limit reached
        logic exact;      // the division left no remainder
        logic out_free;   // the output register can take a result
    } t_status;

endpackage

`default_nettype wire

FILE: sv/prime_factorizer.sv
// An input below two passes the check state and then reports the no-factors result.
// Each trial divisor takes a load, the divider iterations and a decision in the
// one-bit-per-cycle restoring divider; a factor found also takes a report state.
// Output stalls hold the report states; the worst case is a prime close to 2^32.
// One item is in work at a time.
// Reset: synchronous, active low; the block returns idle and the output is empty.
`default_nettype none

module prime_factorizer import pf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [VALUE_W-1:0] i_s_tdata,   // [31:0] value_to_factor
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [VALUE_W-1:0]      o_m_tdata,   // [31:0] prime_factor
    output logic                    o_m_tlast,   // last_factor
    output logic                    o_m_tuser    // [0] no_factors
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer for the trial division loop.
    pf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Remainder, divisor, divider and output register.
    pf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_value    (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/pf_datapath.sv
`default_nettype none

module pf_datapath import pf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [VALUE_W-1:0]      o_m_tdata,
    output logic                    o_m_tlast,
    output logic                    o_m_tuser
);

    logic [VALUE_W-1:0] r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [CNT_W-1:0]   r_count;
    logic [VALUE_W-1:0] r_quo;
    logic [DIV_W-1:0]   r_part;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_data;
    logic               r_out_last;
    logic               r_out_none;

    logic [DIV_W:0]     w_shift;
    logic [DIV_W:0]     w_diff;
    logic               w_ge;

    // Restoring division: shift in one dividend bit, subtract when it fits.
    assign w_shift = {r_part, r_quo[VALUE_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    // Factoring state and divider registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_div   <= FIRST_DIVISOR;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_rem   <= i_value;
                r_div   <= FIRST_DIVISOR;
                r_count <= '0;
            end
            if (i_cmd.inc_div) begin
                r_div <= r_div + DIV_W'(1);
            end
            if (i_cmd.emit_div) begin
                r_rem   <= r_quo;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load_div) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // Quotient and partial remainder carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo  <= r_rem;
            r_part <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[VALUE_W-2:0], w_ge};
            r_part <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
        end
    end

    // Output register: holds one result until the downstream transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_div || i_cmd.emit_rem || i_cmd.emit_none) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_div) begin
            r_out_data <= {{(VALUE_W-DIV_W){1'b0}}, r_div};
            r_out_last <= 1'b0;
            r_out_none <= 1'b0;
        end else if (i_cmd.emit_rem) begin
            r_out_data <= r_rem;
            r_out_last <= 1'b1;
            r_out_none <= 1'b0;
        end else if (i_cmd.emit_none) begin
            r_out_data <= '0;
            r_out_last <= 1'b1;
            r_out_none <= 1'b1;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.rem_small  = (r_rem[VALUE_W-1:1] == '0);
        o_status.div_done   = (r_step == STEP_LAST);
        o_status.stop_trial = ({{(VALUE_W-DIV_W){1'b0}}, r_div} > r_quo)
                              || (r_count == COUNT_LIMIT);
        o_status.exact      = (r_part == '0);
        o_status.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_none;

    // Only one result is written per cycle.
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.emit_div, i_cmd.emit_rem, i_cmd.emit_none}))
        else $error("more than one result written in a cycle");

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_div || i_cmd.emit_rem || i_cmd.emit_none) |-> o_status.out_free)
        else $error("result written over a pending result");

    // A divisor is reported only when it divides the remainder evenly.
    a_exact_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_div |-> (o_status.exact && !o_status.stop_trial))
        else $error("divisor reported without exact division");

    // The trial divisor stays within the square root bound.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div <= (DIV_W'(1) << (DIV_W - 1)))
        else $error("trial divisor out of range");

endmodule

`default_nettype wire

FILE: sv/pf_controller.sv
`default_nettype none

module pf_controller import pf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_EMIT_D = 3'd5;
    localparam logic [2:0] S_EMIT_R = 3'd6;
    localparam logic [2:0] S_EMIT_N = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.rem_small ? S_EMIT_N : S_START;
            end
            S_START: begin
                o_cmd.load_div = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_status.stop_trial) begin
                    n_state = S_EMIT_R;
                end else if (i_status.exact) begin
                    n_state = S_EMIT_D;
                end else begin
                    o_cmd.inc_div = 1'b1;
                    n_state       = S_START;
                end
            end
            S_EMIT_D: begin
                if (i_status.out_free) begin
                    o_cmd.emit_div = 1'b1;
                    n_state        = S_START;
                end
            end
            S_EMIT_R: begin
                if (i_status.out_free) begin
                    o_cmd.emit_rem = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_EMIT_N: begin
                if (i_status.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/prime_factorizer_test.sv
`timescale 1ns / 100ps

module prime_factorizer_test import pf_pkg::*; ();

    // One reported factor as it appears on the output stream.
    typedef struct packed {
        logic [VALUE_W-1:0] prime;
        logic               last;
        logic               none;
    } t_factor;

    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT = 200000;
    // Quiet cycles after the last result, in case a stray result follows.
    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned VALUE_MAX = 64'h0000_0000_FFFF_FFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [VALUE_W-1:0] i_s_tdata = '0;     // [31:0] value_to_factor
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [VALUE_W-1:0] o_m_tdata;          // [31:0] prime_factor
    logic               o_m_tlast;          // last_factor
    logic               o_m_tuser;          // [0] no_factors

    t_factor factor_queue[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      ready_hold = 0;
    bit      idle_enable = 1'b1;

    prime_factorizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Trial division with the same stopping rule and result cap as the block.
    task automatic predict_factors(input logic [VALUE_W-1:0] value);
        longint unsigned rest;
        longint unsigned divisor;
        t_factor         run[$];
        t_factor         entry;
        rest = longint'(value);
        divisor = 2;
        if (rest < 2) begin
            entry.prime = '0;
            entry.last = 1'b1;
            entry.none = 1'b1;
            run.push_back(entry);
        end else begin
            while (divisor <= rest / divisor && run.size() < int'(COUNT_LIMIT)) begin
                if (rest % divisor == 0) begin
                    entry.prime = divisor[VALUE_W-1:0];
                    entry.last = 1'b0;
                    entry.none = 1'b0;
                    run.push_back(entry);
                    rest = rest / divisor;
                end else begin
                    divisor++;
                end
            end
            // Whatever is left above one is the largest prime factor.
            if (rest > 1) begin
                entry.prime = rest[VALUE_W-1:0];
                entry.last = 1'b0;
                entry.none = 1'b0;
                run.push_back(entry);
            end
            run[run.size()-1].last = 1'b1;
        end
        foreach (run[k]) factor_queue.push_back(run[k]);
    endtask

    // Sends one number, with an optional idle burst ahead of it, and records its factors.
    // The valid stays high on return so that the next number can follow without a gap.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= value;
        do @(posedge i_clk); while (!o_s_tready);
        predict_factors(value);
    endtask

    // Drops the valid at the current edge.
    task automatic stop_input();
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (factor_queue.size() != 0) @(posedge i_clk);
    endtask

    // Random number whose factoring stays cheap: small prime factors, at most one
    // moderate cofactor, or a short value.
    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned product;
        longint unsigned factor;
        int              steps;
        int              kind;
        kind = $urandom_range(0, 9);
        product = 1;
        unique case (kind)
            0, 1: begin
                // Short random value, any bit pattern in the low bits.
                product = longint'($urandom() >> $urandom_range(14, 31));
            end
            2: begin
                // Power of one small base.
                factor = $urandom_range(2, 40);
                product = factor;
                while (product * factor <= VALUE_MAX && $urandom_range(0, 7) != 0)
                    product = product * factor;
            end
            3: begin
                product = $urandom_range(0, 1000);
            end
            default: begin
                // Smooth part, on top of a moderate cofactor for some numbers.
                if (kind >= 7) product = $urandom_range(1, 16383);
                steps = $urandom_range(1, 40);
                for (int k = 0; k < steps; k++) begin
                    factor = $urandom_range(2, 97);
                    if (product * factor > VALUE_MAX) break;
                    product = product * factor;
                end
            end
        endcase
        return product[VALUE_W-1:0];
    endfunction

    // Output side: random backpressure and the check of every result transaction.
    always @(posedge i_clk) begin
        t_factor want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (factor_queue.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d last %b none %b",
                         $time, o_m_tdata, o_m_tlast, o_m_tuser);
                error_count++;
            end else begin
                want = factor_queue.pop_front();
                if (o_m_tdata !== want.prime) begin
                    $display("%0t: prime_factor mismatch: expected %0d, actual %0d",
                             $time, want.prime, o_m_tdata);
                    error_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: last_factor mismatch: expected %b, actual %b",
                             $time, want.last, o_m_tlast);
                    error_count++;
                end
                if (o_m_tuser !== want.none) begin
                    $display("%0t: no_factors mismatch: expected %b, actual %b",
                             $time, want.none, o_m_tuser);
                    error_count++;
                end
            end
        end
        // Stalls come in bursts whose length is drawn into ready_hold.
        if (ready_hold > 0) begin
            ready_hold--;
            i_m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 7);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no transaction happens on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("prime_factorizer verification failed");
            $finish;
        end
    end

    // Inputs below two, and the smallest primes and composites.
    task automatic test_small_values();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'd4);
        send_value(32'd6);
        send_value(32'd12);
        send_value(32'd97);
    endtask

    // Values that reach the top bits and the longest runs of factors.
    task automatic test_extremes();
        send_value(32'hFFFF_FFFF);      // 3 * 5 * 17 * 257 * 65537
        send_value(32'h8000_0000);      // 2^31, the longest run
        send_value(32'hC000_0000);      // 3 * 2^30
        send_value(32'hFFFF_0000);
        send_value(32'hAAAA_AAAA);
        send_value(32'h5555_5555);
        send_value(32'd4294836225);     // 65535 squared
    endtask

    // Prime squares, a prime left over after trial division, many distinct primes.
    task automatic test_prime_shapes();
        send_value(32'd10201);          // 101 squared
        send_value(32'd65521);
        send_value(32'd131074);         // 2 * 65537
        send_value(32'd223092870);      // product of the first nine primes
        send_value(32'd49);
    endtask

    // The sender holds off until every result of earlier numbers has come out.
    task automatic test_pause_for_drain();
        send_value(32'd360);
        send_value(32'd1);
        stop_input();
        @(posedge i_clk);
        wait_for_drain();
        send_value(32'd1024);
    endtask

    task automatic test_random_mix(input int count);
        for (int k = 0; k < count; k++) send_value(pick_value());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_values();
        test_extremes();
        test_prime_shapes();
        test_pause_for_drain();
        test_random_mix(60);
        // Last stretch runs without idling on either side.
        idle_enable = 1'b0;
        test_random_mix(20);

        stop_input();
        @(posedge i_clk);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && factor_queue.size() == 0) begin
            $display("prime_factorizer verification clean");
        end else begin
            $display("prime_factorizer verification failed");
        end
        $finish;
    end

endmodule

FILE: prime_factorizer.f
sv/pf_pkg.sv
sv/pf_datapath.sv
sv/pf_controller.sv
sv/prime_factorizer.sv
tb/prime_factorizer_test.sv
